FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/olc_pkg.sv
// Shared types, constants and helper functions of the occupancy light controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package olc_pkg;

  // Widths fixed by the register and field definitions
  localparam int unsigned THR_W       = 12;
  localparam int unsigned AUTO_OFF_W  = 16;
  localparam int unsigned DEBOUNCE_W  = 10;
  localparam int unsigned POWER_W     = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned SINCE_MOT_W = 17;
  localparam int unsigned SINCE_EDG_W = 11;
  localparam int unsigned ON_TICKS_W  = 40;
  localparam int unsigned ENERGY_W    = 48;
  localparam int unsigned ADD_W       = POWER_W + PCT_W;
  localparam int unsigned LIGHT_MAX_W = 16;

  // Defaults for top-level parameters
  localparam int unsigned LIGHT_BITS_DEF  = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Register reset values
  localparam logic [THR_W-1:0]      LIGHT_ON_RST    = 12'd2500;
  localparam logic [THR_W-1:0]      BRIGHT_LOW_RST  = 12'd3000;
  localparam logic [THR_W-1:0]      BRIGHT_MED_RST  = 12'd1000;
  localparam logic [AUTO_OFF_W-1:0] AUTO_OFF_RST    = 16'd60000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST    = 10'd100;
  localparam logic [POWER_W-1:0]    MAX_POWER_RST   = 8'd50;

  // Brightness tiers and matching duty values (pct * 255 / 100)
  localparam logic [PCT_W-1:0]  PCT_OFF   = 7'd0;
  localparam logic [PCT_W-1:0]  PCT_LOW   = 7'd33;
  localparam logic [PCT_W-1:0]  PCT_MED   = 7'd66;
  localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 8'd0;
  localparam logic [DUTY_W-1:0] DUTY_LOW  = 8'd84;
  localparam logic [DUTY_W-1:0] DUTY_MED  = 8'd168;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_ON  = 3'd0,
    REG_BRT_LOW   = 3'd1,
    REG_BRT_MED   = 3'd2,
    REG_AUTO_OFF  = 3'd3,
    REG_DEBOUNCE  = 3'd4,
    REG_MAX_POWER = 3'd5
  } cfg_idx_e;

  // Operation the back end carries out
  typedef enum logic [1:0] {
    OP_TICK,
    OP_ON,
    OP_OFF,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [THR_W-1:0]      light_on;
    logic [THR_W-1:0]      bright_low;
    logic [THR_W-1:0]      bright_med;
    logic [AUTO_OFF_W-1:0] auto_off;
    logic [DEBOUNCE_W-1:0] debounce;
    logic [POWER_W-1:0]    max_power;
  } cfg_t;

  // Classified item; the light sample travels beside it
  typedef struct packed {
    op_e              op;
    logic             raw;
    logic             dark;   // sample below switch-on threshold
    logic [PCT_W-1:0] tier;   // brightness tier of the sample
  } item_t;

  // Brightness tier for a light level
  function automatic logic [PCT_W-1:0] tier_pct(input logic [LIGHT_MAX_W-1:0] light,
                                                input cfg_t cfg);
    if (light > LIGHT_MAX_W'(cfg.bright_low)) begin
      return PCT_LOW;
    end else if (light >= LIGHT_MAX_W'(cfg.bright_med)) begin
      return PCT_MED;
    end
    return PCT_FULL;
  endfunction

  // PWM duty for a brightness tier
  function automatic logic [DUTY_W-1:0] pct_duty(input logic [PCT_W-1:0] pct);
    case (pct)
      PCT_LOW:  return DUTY_LOW;
      PCT_MED:  return DUTY_MED;
      PCT_FULL: return DUTY_FULL;
      default:  return DUTY_OFF;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/olc_front.sv
// Front end: decodes the command and classifies the light sample.
// Depends on olc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olc_front #(
  parameter int unsigned LIGHT_BITS = olc_pkg::LIGHT_BITS_DEF
) (
  input  wire logic [1:0]            cmd_i,
  input  wire logic                  motion_raw_i,
  input  wire logic [LIGHT_BITS-1:0] light_sample_i,
  input  wire olc_pkg::cfg_t         cfg_i,
  output olc_pkg::item_t             item_o
);
  import olc_pkg::*;

  logic [LIGHT_MAX_W-1:0] light_ext;

  assign light_ext = LIGHT_MAX_W'(light_sample_i);

  // Command decode and sample classification against the thresholds
  always_comb begin
    item_o.raw  = motion_raw_i;
    item_o.dark = light_ext < LIGHT_MAX_W'(cfg_i.light_on);
    item_o.tier = tier_pct(light_ext, cfg_i);
    unique case (cmd_e'(cmd_i))
      CMD_TICK: item_o.op = OP_TICK;
      CMD_ON:   item_o.op = OP_ON;
      CMD_OFF:  item_o.op = OP_OFF;
      default:  item_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/olc_queue.sv
// Short first-in first-out queue between front and back end.
// Depends on olc_pkg for defaults only.
`timescale 1ns / 1ps
`default_nettype none

module olc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = olc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/olc_back.sv
// Back end: lamp state, debounce, timers and accumulators; holds the result.
// Depends on olc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olc_back #(
  parameter int unsigned LIGHT_BITS = olc_pkg::LIGHT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire olc_pkg::cfg_t                 cfg_i,
  input  wire logic                          q_valid_i,
  input  wire olc_pkg::item_t                item_i,
  input  wire logic [LIGHT_BITS-1:0]         light_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               lights_on_o,
  output logic [olc_pkg::DUTY_W-1:0]         pwm_duty_o,
  output logic [olc_pkg::PCT_W-1:0]          brightness_pct_o,
  output logic                               motion_seen_o,
  output logic                               manual_mode_o,
  output logic [olc_pkg::ON_TICKS_W-1:0]     on_time_ticks_o,
  output logic [olc_pkg::ENERGY_W-1:0]       energy_units_o
);
  import olc_pkg::*;

  logic                   out_valid_q, out_valid_d;
  logic                   lamp_q, lamp_d;
  logic                   motion_q, motion_d;
  logic                   manual_q, manual_d;
  logic [LIGHT_BITS-1:0]  last_light_q, last_light_d;
  logic [PCT_W-1:0]       bright_q, bright_d;
  logic [SINCE_MOT_W-1:0] since_mot_q, since_mot_d, since_mot_inc;
  logic [SINCE_EDG_W-1:0] since_edg_q, since_edg_d, since_edg_inc;
  logic [ON_TICKS_W-1:0]  on_ticks_q, on_ticks_d;
  logic [ENERGY_W-1:0]    energy_q, energy_d;
  logic [ADD_W-1:0]       energy_add;
  logic [ENERGY_W:0]      energy_sum;
  logic                   auto_on, lamp_mid, auto_off;

  // Result slot: take the next item when the slot is empty or being taken
  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  // Saturating timers and per-tick energy
  assign since_mot_inc = (since_mot_q == '1) ? since_mot_q : since_mot_q + SINCE_MOT_W'(1);
  assign since_edg_inc = (since_edg_q == '1) ? since_edg_q : since_edg_q + SINCE_EDG_W'(1);
  assign energy_add    = ADD_W'(cfg_i.max_power) * ADD_W'(item_i.tier);
  assign energy_sum    = {1'b0, energy_q} + (ENERGY_W + 1)'(energy_add);

  // Next state for the popped item
  always_comb begin
    lamp_d       = lamp_q;
    motion_d     = motion_q;
    manual_d     = manual_q;
    last_light_d = last_light_q;
    bright_d     = bright_q;
    since_mot_d  = since_mot_q;
    since_edg_d  = since_edg_q;
    on_ticks_d   = on_ticks_q;
    energy_d     = energy_q;
    auto_on      = 1'b0;
    lamp_mid     = lamp_q;
    auto_off     = 1'b0;
    if (pop_o) begin
      unique case (item_i.op)
        OP_TICK: begin
          last_light_d = light_i;
          since_mot_d  = since_mot_inc;
          since_edg_d  = since_edg_inc;
          // debounce: accept a change only after the hold-off
          if ((item_i.raw != motion_q) &&
              (since_edg_inc > SINCE_EDG_W'(cfg_i.debounce))) begin
            motion_d    = item_i.raw;
            since_edg_d = '0;
            if (item_i.raw) begin
              since_mot_d = '0;
            end
          end
          // automatic switch on, then timeout or enough light
          auto_on = !manual_q && motion_d && item_i.dark && !lamp_q;
          if (auto_on) begin
            since_mot_d = '0;
          end
          lamp_mid = lamp_q || auto_on;
          auto_off = !manual_q && lamp_mid &&
                     ((since_mot_d > SINCE_MOT_W'(cfg_i.auto_off)) || !item_i.dark);
          lamp_d   = lamp_mid && !auto_off;
          bright_d = lamp_d ? item_i.tier : PCT_OFF;
          if (lamp_d) begin
            if (on_ticks_q != '1) begin
              on_ticks_d = on_ticks_q + ON_TICKS_W'(1);
            end
            energy_d = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
          end
        end
        OP_ON: begin
          if (!lamp_q) begin
            lamp_d      = 1'b1;
            bright_d    = tier_pct(LIGHT_MAX_W'(last_light_q), cfg_i);
            since_mot_d = '0;
          end
          manual_d = 1'b1;
        end
        OP_OFF: begin
          lamp_d   = 1'b0;
          bright_d = PCT_OFF;
          manual_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      lamp_q       <= 1'b0;
      motion_q     <= 1'b0;
      manual_q     <= 1'b0;
      last_light_q <= '0;
      bright_q     <= PCT_OFF;
      since_mot_q  <= '0;
      since_edg_q  <= '0;
      on_ticks_q   <= '0;
      energy_q     <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      lamp_q       <= lamp_d;
      motion_q     <= motion_d;
      manual_q     <= manual_d;
      last_light_q <= last_light_d;
      bright_q     <= bright_d;
      since_mot_q  <= since_mot_d;
      since_edg_q  <= since_edg_d;
      on_ticks_q   <= on_ticks_d;
      energy_q     <= energy_d;
    end
  end

  // State registers hold still while the result waits, so they drive the outputs
  assign out_valid_o      = out_valid_q;
  assign lights_on_o      = lamp_q;
  assign pwm_duty_o       = pct_duty(bright_q);
  assign brightness_pct_o = bright_q;
  assign motion_seen_o    = motion_q;
  assign manual_mode_o    = manual_q;
  assign on_time_ticks_o  = on_ticks_q;
  assign energy_units_o   = energy_q;

endmodule

`default_nettype wire

FILE: rtl/core/occupancy_light_controller.sv
// Occupancy light controller: the input transfer is one 1 ms sample tick
// (cmd 0, raw motion bit and light sample) or a manual on / off command.
// The output transfer carries the lamp state after that item: lights on,
// PWM duty, brightness percent, debounced motion, manual mode, and the
// saturating on-time and energy totals.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user writes them only while no item is in flight; the block does not enforce this.
// The item is written to the queue at the input transfer; the back end then
// updates its state when it pops the item and offers the result.
// Throughput: one item per cycle while the output is not stalled.
// A stalled output holds the result and the back end; further items then fill
// the queue (QUEUE_DEPTH entries, two by default) and in_stall_o rises,
// independent of in_valid_i.
// Reset clears all state, totals and the queue and loads register defaults.
// Depends on olc_pkg, olc_front, olc_queue, olc_back, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_light_controller #(
  parameter int unsigned LIGHT_BITS  = olc_pkg::LIGHT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = olc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [olc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [olc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic                              motion_raw_i,
  input  wire logic [LIGHT_BITS-1:0]             light_sample_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   lights_on_o,
  output logic [olc_pkg::DUTY_W-1:0]             pwm_duty_o,
  output logic [olc_pkg::PCT_W-1:0]              brightness_pct_o,
  output logic                                   motion_seen_o,
  output logic                                   manual_mode_o,
  output logic [olc_pkg::ON_TICKS_W-1:0]         on_time_ticks_o,
  output logic [olc_pkg::ENERGY_W-1:0]           energy_units_o
);
  import olc_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned Q_W = $bits(item_t) + LIGHT_BITS;

  cfg_t                  cfg_q;
  item_t                 front_item, back_item;
  logic                  push, pop, q_full, q_valid;
  logic [Q_W-1:0]        q_wdata, q_rdata;
  logic [LIGHT_BITS-1:0] back_light;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_on   <= LIGHT_ON_RST;
      cfg_q.bright_low <= BRIGHT_LOW_RST;
      cfg_q.bright_med <= BRIGHT_MED_RST;
      cfg_q.auto_off   <= AUTO_OFF_RST;
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.max_power  <= MAX_POWER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LIGHT_ON:  cfg_q.light_on   <= cfg_data_i[THR_W-1:0];
        REG_BRT_LOW:   cfg_q.bright_low <= cfg_data_i[THR_W-1:0];
        REG_BRT_MED:   cfg_q.bright_med <= cfg_data_i[THR_W-1:0];
        REG_AUTO_OFF:  cfg_q.auto_off   <= cfg_data_i[AUTO_OFF_W-1:0];
        REG_DEBOUNCE:  cfg_q.debounce   <= cfg_data_i[DEBOUNCE_W-1:0];
        REG_MAX_POWER: cfg_q.max_power  <= cfg_data_i[POWER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classify the incoming item
  olc_front #(
    .LIGHT_BITS(LIGHT_BITS)
  ) u_front (
    .cmd_i         (cmd_i),
    .motion_raw_i  (motion_raw_i),
    .light_sample_i(light_sample_i),
    .cfg_i         (cfg_q),
    .item_o        (front_item)
  );

  // Queue between front and back end
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;
  assign q_wdata    = {front_item, light_sample_i};

  olc_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign back_item  = item_t'(q_rdata[Q_W-1:LIGHT_BITS]);
  assign back_light = q_rdata[LIGHT_BITS-1:0];

  // Back end: carry out the item and hold the result
  olc_back #(
    .LIGHT_BITS(LIGHT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .item_i          (back_item),
    .light_i         (back_light),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .lights_on_o     (lights_on_o),
    .pwm_duty_o      (pwm_duty_o),
    .brightness_pct_o(brightness_pct_o),
    .motion_seen_o   (motion_seen_o),
    .manual_mode_o   (manual_mode_o),
    .on_time_ticks_o (on_time_ticks_o),
    .energy_units_o  (energy_units_o)
  );

  // Checks on the lamp state
  `ASSERT_ALWAYS(a_manual_lit, !manual_mode_o || lights_on_o, "manual mode with lamp off")
  `ASSERT_ALWAYS(a_tier_lit, lights_on_o == (brightness_pct_o != PCT_OFF), "tier mismatch")
  `ASSERT_NEXT(a_on_mono, 1'b1, on_time_ticks_o >= $past(on_time_ticks_o), "on-time went back")

endmodule

`default_nettype wire

FILE: dv/occupancy_light_controller_tb.sv
// Self-checking testbench for the occupancy light controller: directed and
// random sensor ticks and manual commands, with a lamp predictor stepped per item.
// Depends on olc_pkg and the occupancy_light_controller RTL.
`timescale 1ns / 1ps

module occupancy_light_controller_tb;
  import olc_pkg::*;

  localparam int unsigned LIGHT_W      = 12;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned REPORT_LIMIT = 40;

  typedef struct {
    cmd_e               cmd;
    logic               raw;
    logic [LIGHT_W-1:0] light;
  } sensor_item_t;

  typedef struct packed {
    logic                  lights_on;
    logic [DUTY_W-1:0]     duty;
    logic [PCT_W-1:0]      pct;
    logic                  motion;
    logic                  manual;
    logic [ON_TICKS_W-1:0] on_ticks;
    logic [ENERGY_W-1:0]   energy;
  } lamp_report_t;

  // Clock, reset and DUT-facing signals
  logic clk_i;
  logic rst_n = 1'b0;

  logic                  cfg_we   = 1'b0;
  cfg_idx_e              cfg_idx  = REG_LIGHT_ON;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  cmd_e               cmd      = CMD_TICK;
  logic               raw      = 1'b0;
  logic [LIGHT_W-1:0] light    = '0;
  logic               in_stall;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  lights_on;
  logic [DUTY_W-1:0]     pwm_duty;
  logic [PCT_W-1:0]      brightness_pct;
  logic                  motion_seen;
  logic                  manual_mode;
  logic [ON_TICKS_W-1:0] on_time_ticks;
  logic [ENERGY_W-1:0]   energy_units;

  occupancy_light_controller #(
    .LIGHT_BITS(LIGHT_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .motion_raw_i    (raw),
    .light_sample_i  (light),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .lights_on_o     (lights_on),
    .pwm_duty_o      (pwm_duty),
    .brightness_pct_o(brightness_pct),
    .motion_seen_o   (motion_seen),
    .manual_mode_o   (manual_mode),
    .on_time_ticks_o (on_time_ticks),
    .energy_units_o  (energy_units)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Predictor copy of the register file
  logic [THR_W-1:0]      light_on_cfg   = LIGHT_ON_RST;
  logic [THR_W-1:0]      bright_low_cfg = BRIGHT_LOW_RST;
  logic [THR_W-1:0]      bright_med_cfg = BRIGHT_MED_RST;
  logic [AUTO_OFF_W-1:0] auto_off_cfg   = AUTO_OFF_RST;
  logic [DEBOUNCE_W-1:0] debounce_cfg   = DEBOUNCE_RST;
  logic [POWER_W-1:0]    power_cfg      = MAX_POWER_RST;

  // Predictor copy of the lamp state
  logic                   lamp_m         = 1'b0;
  logic                   motion_m       = 1'b0;
  logic                   manual_m       = 1'b0;
  logic [LIGHT_W-1:0]     last_light_m   = '0;
  logic [PCT_W-1:0]       level_m        = '0;
  logic [SINCE_MOT_W-1:0] since_motion_m = '0;
  logic [SINCE_EDG_W-1:0] since_edge_m   = '0;
  logic [ON_TICKS_W-1:0]  on_ticks_m     = '0;
  logic [ENERGY_W-1:0]    energy_m       = '0;

  sensor_item_t pending_items[$];
  lamp_report_t expected_reports[$];
  int unsigned  queued_count   = 0;
  int unsigned  accepted_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  burst_left     = 0;
  int unsigned  gap_left       = 0;
  int unsigned  stall_mode     = 0;
  int unsigned  stall_left     = 0;
  int unsigned  stall_phase    = 0;

  // Brightness tier of a light level under the current thresholds
  function automatic logic [PCT_W-1:0] brightness_for(input logic [LIGHT_W-1:0] lvl);
    if (lvl > bright_low_cfg) return PCT_LOW;
    if (lvl >= bright_med_cfg) return PCT_MED;
    return PCT_FULL;
  endfunction

  function automatic void lamp_on_model();
    if (!lamp_m) begin
      level_m        = brightness_for(last_light_m);
      lamp_m         = 1'b1;
      since_motion_m = '0;
    end
  endfunction

  function automatic void lamp_off_model();
    if (lamp_m) begin
      lamp_m   = 1'b0;
      level_m  = '0;
      manual_m = 1'b0;
    end
  endfunction

  // Apply one item to the lamp state and return the report it produces
  function automatic lamp_report_t advance_lamp_model(input sensor_item_t item);
    lamp_report_t       rpt;
    logic [ENERGY_W:0]  energy_sum;
    case (item.cmd)
      CMD_TICK: begin
        last_light_m = item.light;
        if (since_motion_m != '1) since_motion_m++;
        if (since_edge_m != '1) since_edge_m++;
        // debounce: accept a change only once the hold time has passed
        if (item.raw != motion_m && since_edge_m > debounce_cfg) begin
          motion_m     = item.raw;
          since_edge_m = '0;
          if (item.raw) since_motion_m = '0;
        end
        if (lamp_m) level_m = brightness_for(last_light_m);
        if (!manual_m) begin
          if (motion_m && last_light_m < light_on_cfg && !lamp_m) lamp_on_model();
          if (lamp_m && (since_motion_m > auto_off_cfg || last_light_m >= light_on_cfg)) begin
            lamp_off_model();
          end
        end
        // lit tick: accumulate on-time and energy, both saturating
        if (lamp_m) begin
          if (on_ticks_m != '1) on_ticks_m++;
          energy_sum = {1'b0, energy_m} + power_cfg * level_m;
          energy_m   = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
        end else begin
          level_m = '0;
        end
      end
      CMD_ON: begin
        lamp_on_model();
        manual_m = 1'b1;
      end
      CMD_OFF: begin
        lamp_off_model();
        manual_m = 1'b0;
      end
      default: ;
    endcase
    rpt.lights_on = lamp_m;
    rpt.duty      = DUTY_W'((32'(level_m) * 255) / 100);
    rpt.pct       = level_m;
    rpt.motion    = motion_m;
    rpt.manual    = manual_m;
    rpt.on_ticks  = on_ticks_m;
    rpt.energy    = energy_m;
    return rpt;
  endfunction

  // Driver: presents pending items in bursts separated by random gaps
  always @(posedge clk_i or negedge rst_n) begin : driver
    sensor_item_t next_item;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(advance_lamp_model('{cmd, raw, light}));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          cmd      <= next_item.cmd;
          raw      <= next_item.raw;
          light    <= next_item.light;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Monitor: checks each output transfer and drives a shifting stall pattern
  always @(posedge clk_i or negedge rst_n) begin : monitor
    lamp_report_t want;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
      stall_phase <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: transfer with no report expected, lights_on %0h energy %0h",
                     $time, lights_on, energy_units);
          end
        end else begin
          want = expected_reports.pop_front();
          check_field("lights_on", want.lights_on, lights_on);
          check_field("pwm_duty", want.duty, pwm_duty);
          check_field("brightness_pct", want.pct, brightness_pct);
          check_field("motion_seen", want.motion, motion_seen);
          check_field("manual_mode", want.manual, manual_mode);
          check_field("on_time_ticks", want.on_ticks, on_time_ticks);
          check_field("energy_units", want.energy, energy_units);
        end
      end
      // stall modes: none, light random, periodic, heavy random
      stall_phase <= stall_phase + 1;
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 30);
        2:       out_stall <= (stall_phase % 3 == 0);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[occupancy_light_controller] ERROR");
      $finish;
    end
  end

  task automatic queue_item(input cmd_e c, input logic r, input logic [LIGHT_W-1:0] lvl);
    sensor_item_t item;
    item.cmd   = c;
    item.raw   = r;
    item.light = lvl;
    pending_items.push_back(item);
    queued_count++;
  endtask

  // Wait until every queued item has been taken and its report checked
  task automatic drain();
    while (accepted_count != queued_count || expected_reports.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_LIGHT_ON:  light_on_cfg   = value[THR_W-1:0];
      REG_BRT_LOW:   bright_low_cfg = value[THR_W-1:0];
      REG_BRT_MED:   bright_med_cfg = value[THR_W-1:0];
      REG_AUTO_OFF:  auto_off_cfg   = value[AUTO_OFF_W-1:0];
      REG_DEBOUNCE:  debounce_cfg   = value[DEBOUNCE_W-1:0];
      REG_MAX_POWER: power_cfg      = value[POWER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input int unsigned on_thr, input int unsigned low_thr,
                               input int unsigned med_thr, input int unsigned off_ticks,
                               input int unsigned deb, input int unsigned watts);
    write_reg(REG_LIGHT_ON, CFG_DATA_W'(on_thr));
    write_reg(REG_BRT_LOW, CFG_DATA_W'(low_thr));
    write_reg(REG_BRT_MED, CFG_DATA_W'(med_thr));
    write_reg(REG_AUTO_OFF, CFG_DATA_W'(off_ticks));
    write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
    write_reg(REG_MAX_POWER, CFG_DATA_W'(watts));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random traffic: motion held in runs of up to 2 * debounce + timeout + 4 items,
  // at most 80, light clustered near the thresholds and in the dark band,
  // with some glitches, manual commands and unused command codes mixed in.
  task automatic queue_traffic(input int unsigned count);
    int unsigned run_left;
    int unsigned run_cap;
    int unsigned pick;
    int          light_val;
    logic        level;
    cmd_e        c;
    run_left = 0;
    level    = 1'b0;
    run_cap  = 2 * debounce_cfg + auto_off_cfg + 4;
    if (run_cap > 80) run_cap = 80;
    for (int unsigned n = 0; n < count; n++) begin
      if (run_left == 0) begin
        level    = ~level;
        run_left = $urandom_range(1, run_cap);
      end
      run_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) c = CMD_ON;
      else if (pick < 8) c = CMD_OFF;
      else if (pick < 10) c = CMD_NONE;
      else c = CMD_TICK;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        light_val = $urandom_range(0, 4095);
      end else if (pick < 60) begin
        case ($urandom_range(0, 2))
          0:       light_val = light_on_cfg;
          1:       light_val = bright_low_cfg;
          default: light_val = bright_med_cfg;
        endcase
        light_val += int'($urandom_range(0, 4)) - 2;
        if (light_val < 0) light_val = 0;
        if (light_val > 4095) light_val = 4095;
      end else begin
        light_val = (light_on_cfg == 0) ? 0 : $urandom_range(0, int'(light_on_cfg) - 1);
      end
      queue_item(c, ($urandom_range(0, 19) == 0) ? ~level : level, LIGHT_W'(light_val));
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed: manual on/off from both lamp states, unused code, tier edges
    queue_item(CMD_NONE, 1'b1, 12'd4095);
    queue_item(CMD_ON, 1'b0, 12'd0);
    queue_item(CMD_ON, 1'b1, 12'd4095);
    queue_item(CMD_NONE, 1'b0, 12'd0);
    queue_item(CMD_TICK, 1'b1, 12'd4095);
    queue_item(CMD_TICK, 1'b0, 12'd0);
    queue_item(CMD_TICK, 1'b1, 12'd1000);
    queue_item(CMD_TICK, 1'b0, 12'd999);
    queue_item(CMD_TICK, 1'b1, 12'd3000);
    queue_item(CMD_TICK, 1'b1, 12'd3001);
    queue_item(CMD_OFF, 1'b0, 12'd0);
    queue_item(CMD_OFF, 1'b1, 12'd4095);
    queue_item(CMD_TICK, 1'b1, 12'd2499);
    queue_item(CMD_ON, 1'b0, 12'd0);
    queue_item(CMD_TICK, 1'b0, 12'd2500);
    queue_item(CMD_NONE, 1'b1, 12'd2047);
    queue_item(CMD_OFF, 1'b0, 12'd2048);
    queue_item(CMD_TICK, 1'b0, 12'd1365);
    queue_item(CMD_TICK, 1'b1, 12'd2730);
    queue_item(CMD_ON, 1'b1, 12'd0);
    queue_item(CMD_TICK, 1'b0, 12'd0);
    queue_item(CMD_OFF, 1'b1, 12'd4095);
    drain();

    // Extremes: dark below full scale, flat 66 percent tier, timers of 1
    set_registers(4095, 4095, 0, 1, 1, 255);
    queue_traffic(100);
    drain();

    // Extremes: never dark, 33 percent for any nonzero sample, longest timers, zero power
    set_registers(0, 0, 4095, 65535, 1023, 0);
    queue_traffic(60);
    drain();

    // Random settings with short timers
    for (int p = 0; p < 7; p++) begin
      set_registers($urandom_range(500, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(1, 40),
                    $urandom_range(1, 8), $urandom_range(0, 255));
      queue_traffic(110);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("[occupancy_light_controller] OK");
    end else begin
      $display("[occupancy_light_controller] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/olc_pkg.sv
rtl/core/olc_front.sv
rtl/core/olc_queue.sv
rtl/core/olc_back.sv
rtl/core/occupancy_light_controller.sv
dv/occupancy_light_controller_tb.sv
